[rtl/mrm_pkg.sv]
// Shared types, command codes and the CRC-16 byte step for the Modbus RTU master.
// No dependencies; used by mrm_ctrl, mrm_dp and the top level.
`default_nettype none
package mrm_pkg;
	localparam int CntW = 7;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_PAYLOAD = 2'd1;
	localparam logic [1:0] ACT_RXBYTE = 2'd2;
	localparam logic [1:0] ACT_WINEND = 2'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_RECV = 2'd2;

	localparam logic [1:0] KIND_TX = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	localparam logic [0:0] REG_WFC = 1'd0;
	localparam logic [0:0] REG_RS485 = 1'd1;

	// Datapath operations other than emitting a word.
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_ABORT = 2'd1;
	localparam logic [1:0] OP_RX = 2'd2;
	localparam logic [1:0] OP_END = 2'd3;

	// Emit selections.
	localparam logic [3:0] E_ADDR = 4'd0;
	localparam logic [3:0] E_FUNC = 4'd1;
	localparam logic [3:0] E_SRH = 4'd2;
	localparam logic [3:0] E_SRL = 4'd3;
	localparam logic [3:0] E_CNH = 4'd4;
	localparam logic [3:0] E_CNL = 4'd5;
	localparam logic [3:0] E_BCNT = 4'd6;
	localparam logic [3:0] E_DATA = 4'd7;
	localparam logic [3:0] E_CRCL = 4'd8;
	localparam logic [3:0] E_CRCH = 4'd9;
	localparam logic [3:0] E_PAD = 4'd10;
	localparam logic [3:0] E_STAT = 4'd11;
	localparam logic [3:0] E_WORD = 4'd12;

	// Reply buffer read and check selections.
	localparam logic [2:0] RB_CRCL = 3'd0;
	localparam logic [2:0] RB_CRCH = 3'd1;
	localparam logic [2:0] RB_ADDR = 3'd2;
	localparam logic [2:0] RB_FUNC = 3'd3;
	localparam logic [2:0] RB_BCNT = 3'd4;
	localparam logic [2:0] RB_WH = 3'd5;
	localparam logic [2:0] RB_WL = 3'd6;

	typedef struct packed {
		logic       latch;
		logic [1:0] op;
		logic       emit;
		logic [3:0] esel;
		logic [1:0] st;
		logic       last;
		logic       rd;
		logic [2:0] ra;
		logic       chk;
		logic [2:0] ca;
	} mrm_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] phase;
		logic       bad_count;
		logic       is_write;
		logic       pad;
		logic       payload_last;
		logic       rx_short;
		logic       bad;
		logic       words_zero;
		logic       word_final;
		logic       out_free;
	} mrm_stat_t;

	// One byte through the reflected CRC-16 (polynomial 0xA001).
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ 16'hA001;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction
endpackage
`default_nettype wire

[rtl/mrm_dp.sv]
// Datapath of the Modbus RTU master: saved request, CRC registers, reply buffer
// memory and the output register. Depends on mrm_pkg; driven by mrm_ctrl.
`default_nettype none
module mrm_dp import mrm_pkg::*; #(
	parameter int MAX_REGS = 64,
	parameter int RX_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mrm_cmd_t    cmd,
	output mrm_stat_t        stat,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  dev_addr,
	input  wire logic [7:0]  func_code,
	input  wire logic [15:0] start_reg,
	input  wire logic [15:0] reg_count,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       tx_byte,
	output logic [15:0]      reg_word,
	output logic [1:0]       status,
	output logic             status_valid,
	output logic             last
);
	localparam int AW = $clog2(RX_DEPTH);
	localparam int CW = $clog2(RX_DEPTH + 1);

	logic [7:0]  wfc_q;
	logic        rs485_q;
	logic [1:0]  act_q;
	logic [7:0]  addr_in_q, func_in_q, byte_in_q;
	logic [15:0] sreg_in_q, cnt_in_q;
	logic [1:0]  phase_q;
	logic [7:0]  saved_addr_q, saved_func_q;
	logic [CntW-1:0] saved_count_q;
	logic [7:0]  payload_left_q;
	logic [15:0] tx_crc_q, rx_crc_q;
	logic [CW-1:0] rx_count_q;
	logic        skip_q;
	logic        bad_q;
	logic [CntW-1:0] words_q, word_idx_q;
	logic [7:0]  word_hi_q, word_lo_q;
	logic [7:0]  rdata_q;
	logic [7:0]  rx_mem [RX_DEPTH];

	logic        out_valid_q;
	logic [1:0]  kind_q, status_q;
	logic [7:0]  tx_byte_q;
	logic [15:0] reg_word_q;
	logic        status_valid_q, last_q;

	logic        is_write;
	logic [7:0]  exp_len;
	logic [7:0]  tx_val;
	logic [15:0] crc_base;
	logic        crc_upd;
	logic [AW-1:0] rd_addr;
	logic [8:0]  wh_addr;
	logic [CntW-1:0] half_cnt;
	logic        out_free;

	assign is_write = (saved_func_q == wfc_q);
	assign exp_len  = is_write ? 8'd8 : (8'd5 + {saved_count_q, 1'b0});
	assign out_free = !out_valid_q || out_ready;
	assign wh_addr  = 9'({word_idx_q, 1'b0}) + 9'd3;
	assign half_cnt = rdata_q[7:1];

	always_comb begin
		tx_val  = 8'h00;
		crc_upd = 1'b1;
		case (cmd.esel)
			E_ADDR: tx_val = addr_in_q;
			E_FUNC: tx_val = func_in_q;
			E_SRH:  tx_val = sreg_in_q[15:8];
			E_SRL:  tx_val = sreg_in_q[7:0];
			E_CNH:  tx_val = cnt_in_q[15:8];
			E_CNL:  tx_val = cnt_in_q[7:0];
			E_BCNT: tx_val = {cnt_in_q[6:0], 1'b0};
			E_DATA: tx_val = byte_in_q;
			E_CRCL: begin
				tx_val  = tx_crc_q[7:0];
				crc_upd = 1'b0;
			end
			E_CRCH: begin
				tx_val  = tx_crc_q[15:8];
				crc_upd = 1'b0;
			end
			default: crc_upd = 1'b0;
		endcase
		crc_base = (cmd.esel == E_ADDR) ? 16'hFFFF : tx_crc_q;
	end

	always_comb begin
		case (cmd.ra)
			RB_CRCL: rd_addr = AW'(exp_len - 8'd2);
			RB_CRCH: rd_addr = AW'(exp_len - 8'd1);
			RB_ADDR: rd_addr = AW'(0);
			RB_FUNC: rd_addr = AW'(1);
			RB_BCNT: rd_addr = AW'(2);
			RB_WH:   rd_addr = AW'(wh_addr);
			RB_WL:   rd_addr = AW'(wh_addr + 9'd1);
			default: rd_addr = AW'(0);
		endcase
	end

	// Reply buffer: written by received bytes, read one byte at a time at window end.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_RX && phase_q == PH_RECV && !skip_q && rx_count_q < CW'(RX_DEPTH)) begin
			rx_mem[AW'(rx_count_q)] <= byte_in_q;
		end
		if (cmd.rd) begin
			rdata_q <= rx_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q     <= action;
			addr_in_q <= dev_addr;
			func_in_q <= func_code;
			sreg_in_q <= start_reg;
			cnt_in_q  <= reg_count;
			byte_in_q <= data_byte;
		end
		if (cmd.chk) begin
			case (cmd.ca)
				RB_BCNT: words_q <= (half_cnt > saved_count_q) ? saved_count_q : half_cnt;
				RB_WH:   word_hi_q <= rdata_q;
				RB_WL:   word_lo_q <= rdata_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wfc_q          <= 8'd16;
			rs485_q        <= 1'b1;
			phase_q        <= PH_IDLE;
			saved_addr_q   <= 8'h00;
			saved_func_q   <= 8'h00;
			saved_count_q  <= '0;
			payload_left_q <= 8'h00;
			tx_crc_q       <= 16'hFFFF;
			rx_crc_q       <= 16'hFFFF;
			rx_count_q     <= '0;
			skip_q         <= 1'b0;
			bad_q          <= 1'b0;
			word_idx_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_WFC:   wfc_q <= cfg_wdata;
					REG_RS485: rs485_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_ABORT: phase_q <= PH_IDLE;
				OP_RX: begin
					if (skip_q) begin
						skip_q <= 1'b0;
					end else if (rx_count_q < CW'(RX_DEPTH)) begin
						if (11'(rx_count_q) + 11'd2 < 11'(exp_len)) begin
							rx_crc_q <= crc16_byte(rx_crc_q, byte_in_q);
						end
						rx_count_q <= rx_count_q + CW'(1);
					end
				end
				OP_END: begin
					phase_q    <= PH_IDLE;
					bad_q      <= 1'b0;
					word_idx_q <= '0;
				end
				default: ;
			endcase
			if (cmd.chk) begin
				case (cmd.ca)
					RB_CRCL: if (rdata_q != rx_crc_q[7:0]) bad_q <= 1'b1;
					RB_CRCH: if (rdata_q != rx_crc_q[15:8]) bad_q <= 1'b1;
					RB_ADDR: if (rdata_q != saved_addr_q) bad_q <= 1'b1;
					RB_FUNC: if (rdata_q != saved_func_q) bad_q <= 1'b1;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (crc_upd) begin
					tx_crc_q <= crc16_byte(crc_base, tx_val);
				end
				case (cmd.esel)
					E_ADDR: begin
						saved_addr_q  <= addr_in_q;
						saved_func_q  <= func_in_q;
						saved_count_q <= cnt_in_q[CntW-1:0];
					end
					E_BCNT: begin
						payload_left_q <= tx_val;
						phase_q        <= PH_PAYLOAD;
					end
					E_DATA: payload_left_q <= payload_left_q - 8'd1;
					E_WORD: word_idx_q <= word_idx_q + CntW'(1);
					default: ;
				endcase
				if ((cmd.esel == E_CRCH && !rs485_q) || cmd.esel == E_PAD) begin
					phase_q    <= PH_RECV;
					rx_count_q <= '0;
					rx_crc_q   <= 16'hFFFF;
					skip_q     <= rs485_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			tx_byte_q      <= 8'h00;
			reg_word_q     <= 16'h0000;
			status_q       <= ST_OK;
			status_valid_q <= 1'b0;
			last_q         <= cmd.last;
			case (cmd.esel)
				E_STAT: begin
					kind_q         <= KIND_STATUS;
					status_q       <= cmd.st;
					status_valid_q <= 1'b1;
				end
				E_WORD: begin
					kind_q         <= KIND_WORD;
					reg_word_q     <= {word_hi_q, word_lo_q};
					status_valid_q <= cmd.last;
				end
				E_PAD: begin
					kind_q <= KIND_TX;
				end
				default: begin
					kind_q    <= KIND_TX;
					tx_byte_q <= tx_val;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign tx_byte      = tx_byte_q;
	assign reg_word     = reg_word_q;
	assign status       = status_q;
	assign status_valid = status_valid_q;
	assign last         = last_q;

	always_comb begin
		stat.action       = act_q;
		stat.phase        = phase_q;
		stat.bad_count    = (cnt_in_q == 16'd0) || (cnt_in_q > 16'(MAX_REGS));
		stat.is_write     = is_write;
		stat.pad          = rs485_q;
		stat.payload_last = (payload_left_q == 8'd1);
		stat.rx_short     = (11'(rx_count_q) < 11'(exp_len));
		stat.bad          = bad_q;
		stat.words_zero   = (words_q == '0);
		stat.word_final   = (word_idx_q + CntW'(1) == words_q);
		stat.out_free     = out_free;
	end
endmodule
`default_nettype wire

[rtl/mrm_ctrl.sv]
// Controller state machine of the Modbus RTU master.
// Depends on mrm_pkg; issues commands to mrm_dp and reads its status.
`default_nettype none
module mrm_ctrl import mrm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire mrm_stat_t stat,
	output mrm_cmd_t       cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_TX   = 4'd2;
	localparam logic [3:0] S_STAT = 4'd3;
	localparam logic [3:0] S_CK0  = 4'd4;
	localparam logic [3:0] S_CK1  = 4'd5;
	localparam logic [3:0] S_CK2  = 4'd6;
	localparam logic [3:0] S_CK3  = 4'd7;
	localparam logic [3:0] S_CK4  = 4'd8;
	localparam logic [3:0] S_CK5  = 4'd9;
	localparam logic [3:0] S_CK6  = 4'd10;
	localparam logic [3:0] S_WH   = 4'd11;
	localparam logic [3:0] S_WL   = 4'd12;
	localparam logic [3:0] S_WC   = 4'd13;
	localparam logic [3:0] S_WE   = 4'd14;

	logic [3:0] state_q, state_d;
	logic [3:0] sel_q, sel_d;
	logic [1:0] st_q, st_d;

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		st_d     = st_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				case (stat.action)
					ACT_START: begin
						if (stat.bad_count) begin
							cmd.op  = OP_ABORT;
							st_d    = ST_COUNT;
							state_d = S_STAT;
						end else begin
							sel_d   = E_ADDR;
							state_d = S_TX;
						end
					end
					ACT_PAYLOAD: begin
						if (stat.phase == PH_PAYLOAD) begin
							sel_d   = E_DATA;
							state_d = S_TX;
						end
					end
					ACT_RXBYTE: begin
						if (stat.phase == PH_RECV) cmd.op = OP_RX;
					end
					default: begin
						if (stat.phase == PH_RECV) begin
							cmd.op = OP_END;
							if (stat.rx_short) begin
								st_d    = ST_SHORT;
								state_d = S_STAT;
							end else begin
								state_d = S_CK0;
							end
						end
					end
				endcase
			end
			S_TX: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = sel_q;
					cmd.last = (sel_q == E_PAD) || (sel_q == E_CRCH && !stat.pad);
					case (sel_q)
						E_CNL: sel_d = stat.is_write ? E_BCNT : E_CRCL;
						E_BCNT: state_d = S_IDLE;
						E_DATA: begin
							if (stat.payload_last) begin
								sel_d = E_CRCL;
							end else begin
								state_d = S_IDLE;
							end
						end
						E_CRCL: sel_d = E_CRCH;
						E_CRCH: begin
							if (stat.pad) begin
								sel_d = E_PAD;
							end else begin
								state_d = S_IDLE;
							end
						end
						E_PAD: state_d = S_IDLE;
						default: sel_d = sel_q + 4'd1;
					endcase
				end
			end
			S_STAT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = E_STAT;
					cmd.st   = st_q;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_CK0: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_CRCL;
				state_d = S_CK1;
			end
			S_CK1: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_CRCH;
				cmd.chk = 1'b1;
				cmd.ca  = RB_CRCL;
				state_d = S_CK2;
			end
			S_CK2: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_ADDR;
				cmd.chk = 1'b1;
				cmd.ca  = RB_CRCH;
				state_d = S_CK3;
			end
			S_CK3: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_FUNC;
				cmd.chk = 1'b1;
				cmd.ca  = RB_ADDR;
				state_d = S_CK4;
			end
			S_CK4: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_BCNT;
				cmd.chk = 1'b1;
				cmd.ca  = RB_FUNC;
				state_d = S_CK5;
			end
			S_CK5: begin
				cmd.chk = 1'b1;
				cmd.ca  = RB_BCNT;
				state_d = S_CK6;
			end
			S_CK6: begin
				if (stat.bad) begin
					st_d    = ST_BAD;
					state_d = S_STAT;
				end else if (stat.is_write || stat.words_zero) begin
					st_d    = ST_OK;
					state_d = S_STAT;
				end else begin
					state_d = S_WH;
				end
			end
			S_WH: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_WH;
				state_d = S_WL;
			end
			S_WL: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RB_WL;
				cmd.chk = 1'b1;
				cmd.ca  = RB_WH;
				state_d = S_WC;
			end
			S_WC: begin
				cmd.chk = 1'b1;
				cmd.ca  = RB_WL;
				state_d = S_WE;
			end
			S_WE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = E_WORD;
					cmd.last = stat.word_final;
					state_d  = stat.word_final ? S_IDLE : S_WH;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= E_ADDR;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			st_q    <= st_d;
		end
	end
endmodule
`default_nettype wire

[rtl/modbus_rtu_master_transaction_core.sv]
// Top level of the Modbus RTU master transaction core.
// Depends on mrm_pkg, mrm_ctrl and mrm_dp.
//
//   Channel   Direction  Handshake             Contents
//   input     in         in_valid / in_ready   action, dev_addr, func_code, start_reg,
//                                              reg_count, data_byte
//   output    out        out_valid / out_ready kind, tx_byte, reg_word, status,
//                                              status_valid, last
//   config    in         cfg_we                cfg_addr, cfg_wdata
//
// Each input word is latched in the idle state and decoded in the next state. A received
// line byte or an ignored word needs nothing more; each transmitted or status word adds
// an emit step that waits for a free output register. At window end the reply buffer is
// read one byte at a time: S_CK0 to S_CK6 check CRC, address and function and take the
// byte count, then S_WH, S_WL, S_WC and S_WE fetch and emit each register word, in an
// order set by the single read port of the reply buffer and the one output register.
// The reset is asynchronous and clears control state only; the buffer needs no clear,
// since only bytes of the current reply are read. A stalled output holds the
// controller in place, and no new word is accepted until the current one is done.
`default_nettype none
module modbus_rtu_master_transaction_core import mrm_pkg::*; #(
	parameter int MAX_REGS = 64,
	parameter int RX_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  dev_addr,
	input  wire logic [7:0]  func_code,
	input  wire logic [15:0] start_reg,
	input  wire logic [15:0] reg_count,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       tx_byte,
	output logic [15:0]      reg_word,
	output logic [1:0]       status,
	output logic             status_valid,
	output logic             last
);
	mrm_cmd_t  cmd;
	mrm_stat_t stat;

	// The controller sequences every word; the datapath holds all transaction state.
	mrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrm_dp #(
		.MAX_REGS (MAX_REGS),
		.RX_DEPTH (RX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.action       (action),
		.dev_addr     (dev_addr),
		.func_code    (func_code),
		.start_reg    (start_reg),
		.reg_count    (reg_count),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.reg_word     (reg_word),
		.status       (status),
		.status_valid (status_valid),
		.last         (last)
	);
endmodule
`default_nettype wire
